[hdl/pits_pkg.sv]
// Shared types and constants for the priority interval task scheduler.
// No dependencies; used by every module under hdl/.
`default_nettype none

package pits_pkg;

    localparam int SLOTS_DEF = 8;

    // Priority values at or above this limit are refused on add.
    localparam logic [7:0] PRIO_LIMIT = 8'hFE;

    // Command codes.
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_POLL = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_DUE  = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IDLE_EN = 1'b0;
    localparam logic CFG_IDLE_ID = 1'b1;

    // One table entry.
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] interval;
        logic [31:0] run_stamp;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_PUT,
        ST_ADD_RESP,
        ST_POLL_EV,
        ST_POLL_IDLE,
        ST_POLL_LAST
    } t_state;

    // Operation of the shared compare unit.
    typedef enum logic {
        CMP_DUE,    // elapsed time reached interval
        CMP_AFTER   // stored priority sorts after the request
    } t_cmp_op;

endpackage

`default_nettype wire

[hdl/pits_slot_mem.sv]
// Task table storage: one write port, one registered read port.
// Depends on pits_pkg (t_slot).
`default_nettype none

module pits_slot_mem #(
    parameter int SLOTS = pits_pkg::SLOTS_DEF,
    localparam int AW   = $clog2(SLOTS)
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire pits_pkg::t_slot i_wr_data,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output pits_pkg::t_slot      o_rd_data
);

    pits_pkg::t_slot r_mem [SLOTS];
    pits_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds while no read is issued; the sequencer relies on that.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/pits_cmp.sv]
// Shared compare unit: due test for poll, ordering test for insert.
// Depends on pits_pkg (t_slot, t_cmp_op).
`default_nettype none

module pits_cmp (
    input  wire pits_pkg::t_cmp_op i_op,
    input  wire pits_pkg::t_slot   i_slot,
    input  wire logic [31:0]       i_ms,
    input  wire logic [7:0]        i_prio,
    output logic                   o_hit
);

    logic [31:0] elapsed;

    // Wrapping elapsed time, modulo 2^32.
    assign elapsed = i_ms - i_slot.run_stamp;

    always_comb begin
        case (i_op)
            pits_pkg::CMP_DUE:   o_hit = elapsed >= {16'b0, i_slot.interval};
            pits_pkg::CMP_AFTER: o_hit = i_slot.prio > i_prio;
            default:             o_hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/priority_interval_task_scheduler.sv]
// Priority interval task scheduler: command sequencer, tick counter, output register.
// Depends on pits_pkg, pits_slot_mem and pits_cmp.
//
// Keeps up to SLOTS periodic tasks sorted by priority (lower first, equal
// priorities in arrival order) and serves three commands: add, tick, poll.
// One item is taken at a time; o_in_stall is high while a command is being
// worked. A tick gives no result. A rejected add (table full counting the
// idle slot, priority 254 or more, zero interval) moves no entries; its
// status is registered once the output register is free. An accepted add
// walks the table from the top down, moving each entry that sorts after
// the new task up by one slot. A poll reads one entry per cycle through the
// single table read port, pausing while a held due result cannot be pushed
// out to make room for the next, and emits every due task, then the idle
// task if enabled and it holds a slot, or one "nothing due" result;
// last_of_run marks the final result of the item.
// One due result is held back until the next is known, so the run end can
// be flagged; a stalled output register stretches the poll accordingly.
// The output side is registered, so a waiting result does not block a
// tick or a reject decision. Configuration writes land at once and are
// expected only while the block is idle. Table contents are not cleared on
// reset; only entries below the task count are ever read.
`default_nettype none

module priority_interval_task_scheduler #(
    parameter int SLOTS = pits_pkg::SLOTS_DEF,
    localparam int AW   = $clog2(SLOTS),
    localparam int CW   = $clog2(SLOTS + 1)
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_wdata,
    // command channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_task_id,
    input  wire logic [7:0]  i_priority_req,
    input  wire logic [15:0] i_interval,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic             o_accepted,
    output logic [7:0]       o_due_id,
    output logic             o_last_of_run
);

    localparam logic [CW:0]   FULL_LIM = (CW + 1)'(SLOTS);
    localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);

    // Control state
    pits_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_ms, n_ms;
    logic             r_idle_en;
    logic [7:0]       r_idle_id;
    logic             r_pend_v, n_pend_v;
    logic [7:0]       r_pend_id, n_pend_id;
    logic             r_out_v, n_out_v;

    // Latched command payload
    logic [7:0]       r_task_id, n_task_id;
    logic [7:0]       r_prio, n_prio;
    logic [15:0]      r_interval, n_interval;
    logic             r_acc, n_acc;

    // Output payload
    logic [1:0]       r_out_kind, n_out_kind;
    logic             r_out_acc, n_out_acc;
    logic [7:0]       r_out_id, n_out_id;
    logic             r_out_last, n_out_last;

    // Table and compare unit hookup
    logic             mem_wr_en, mem_rd_en;
    logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
    pits_pkg::t_slot  mem_wr_data, mem_rd_data, new_slot, moved_slot, stamped_slot;
    pits_pkg::t_cmp_op cmp_op;
    logic             cmp_hit;

    // Shared conditions
    logic             in_acc, out_free, reject, is_last, has_idle, ev_block;
    logic [CW-1:0]    idx_p1;

    pits_slot_mem #(.SLOTS(SLOTS)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign cmp_op = (r_state == pits_pkg::ST_POLL_EV) ? pits_pkg::CMP_DUE
                                                       : pits_pkg::CMP_AFTER;

    pits_cmp u_cmp (
        .i_op   (cmp_op),
        .i_slot (mem_rd_data),
        .i_ms   (r_ms),
        .i_prio (r_prio),
        .o_hit  (cmp_hit)
    );

    assign o_in_stall = (r_state != pits_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_v || !i_out_stall;

    // Idle task holds a slot, so it counts toward the full check.
    assign reject = (({1'b0, r_count} + (CW + 1)'(r_idle_en)) >= FULL_LIM)
                 || (i_priority_req >= pits_pkg::PRIO_LIMIT)
                 || (i_interval == 16'd0);

    assign idx_p1   = CW'(r_idx) + CW'(1);
    assign is_last  = (idx_p1 >= r_count);
    assign has_idle = r_idle_en && (r_count < SLOTS_C);
    // A second due task needs the held one pushed out first.
    assign ev_block = cmp_hit && r_pend_v && !out_free;

    always_comb begin
        new_slot          = '0;
        new_slot.id       = r_task_id;
        new_slot.prio     = r_prio;
        new_slot.interval = r_interval;
        moved_slot        = mem_rd_data;
        stamped_slot      = mem_rd_data;
        stamped_slot.run_stamp = r_ms;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pits_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_command)
                        pits_pkg::CMD_ADD: begin
                            if (reject) begin
                                n_state = pits_pkg::ST_ADD_RESP;
                            end else if (r_count == '0) begin
                                n_state = pits_pkg::ST_ADD_PUT;
                            end else begin
                                n_state = pits_pkg::ST_ADD_SCAN;
                            end
                        end
                        pits_pkg::CMD_POLL: begin
                            n_state = (r_count == '0) ? pits_pkg::ST_POLL_IDLE
                                                      : pits_pkg::ST_POLL_EV;
                        end
                        default: n_state = pits_pkg::ST_IDLE;
                    endcase
                end
            end
            pits_pkg::ST_ADD_SCAN: begin
                if (!cmp_hit) begin
                    n_state = pits_pkg::ST_ADD_RESP;
                end else if (r_idx == '0) begin
                    n_state = pits_pkg::ST_ADD_PUT;
                end
            end
            pits_pkg::ST_ADD_PUT: n_state = pits_pkg::ST_ADD_RESP;
            pits_pkg::ST_ADD_RESP: begin
                if (out_free) begin
                    n_state = pits_pkg::ST_IDLE;
                end
            end
            pits_pkg::ST_POLL_EV: begin
                if (!ev_block && is_last) begin
                    n_state = pits_pkg::ST_POLL_IDLE;
                end
            end
            pits_pkg::ST_POLL_IDLE: begin
                if (!has_idle || !r_pend_v || out_free) begin
                    n_state = pits_pkg::ST_POLL_LAST;
                end
            end
            pits_pkg::ST_POLL_LAST: begin
                if (out_free) begin
                    n_state = pits_pkg::ST_IDLE;
                end
            end
            default: n_state = pits_pkg::ST_IDLE;
        endcase
    end

    // Datapath, table access and result register loads
    always_comb begin
        n_idx      = r_idx;
        n_count    = r_count;
        n_ms       = r_ms;
        n_pend_v   = r_pend_v;
        n_pend_id  = r_pend_id;
        n_task_id  = r_task_id;
        n_prio     = r_prio;
        n_interval = r_interval;
        n_acc      = r_acc;
        n_out_v    = r_out_v && i_out_stall;
        n_out_kind = r_out_kind;
        n_out_acc  = r_out_acc;
        n_out_id   = r_out_id;
        n_out_last = r_out_last;

        mem_wr_en   = 1'b0;
        mem_wr_addr = r_idx;
        mem_wr_data = new_slot;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_idx;

        case (r_state)
            pits_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_task_id  = i_task_id;
                    n_prio     = i_priority_req;
                    n_interval = i_interval;
                    n_acc      = !reject;
                    n_pend_v   = 1'b0;
                    case (i_command)
                        pits_pkg::CMD_ADD: begin
                            // Walk starts at the top entry.
                            n_idx       = AW'(r_count - CW'(1));
                            mem_rd_addr = AW'(r_count - CW'(1));
                            mem_rd_en   = !reject && (r_count != '0);
                            if (r_count == '0) begin
                                n_idx = '0;
                            end
                        end
                        pits_pkg::CMD_TICK: n_ms = r_ms + 32'd1;
                        pits_pkg::CMD_POLL: begin
                            n_idx       = '0;
                            mem_rd_addr = '0;
                            mem_rd_en   = (r_count != '0);
                        end
                        default: ;
                    endcase
                end
            end
            pits_pkg::ST_ADD_SCAN: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(idx_p1);
                if (cmp_hit) begin
                    // Entry sorts after the new task: move it up one slot.
                    mem_wr_data = moved_slot;
                    if (r_idx != '0) begin
                        n_idx       = r_idx - AW'(1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = r_idx - AW'(1);
                    end
                end else begin
                    mem_wr_data = new_slot;
                    n_count     = r_count + CW'(1);
                end
            end
            pits_pkg::ST_ADD_PUT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = '0;
                mem_wr_data = new_slot;
                n_count     = r_count + CW'(1);
            end
            pits_pkg::ST_ADD_RESP: begin
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_kind = pits_pkg::KIND_ADD;
                    n_out_acc  = r_acc;
                    n_out_id   = '0;
                    n_out_last = 1'b1;
                end
            end
            pits_pkg::ST_POLL_EV: begin
                if (!ev_block) begin
                    if (cmp_hit) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_idx;
                        mem_wr_data = stamped_slot;
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_kind = pits_pkg::KIND_DUE;
                            n_out_acc  = 1'b0;
                            n_out_id   = r_pend_id;
                            n_out_last = 1'b0;
                        end
                        n_pend_v  = 1'b1;
                        n_pend_id = mem_rd_data.id;
                    end
                    if (!is_last) begin
                        n_idx       = AW'(idx_p1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(idx_p1);
                    end
                end
            end
            pits_pkg::ST_POLL_IDLE: begin
                if (has_idle && (!r_pend_v || out_free)) begin
                    if (r_pend_v) begin
                        n_out_v    = 1'b1;
                        n_out_kind = pits_pkg::KIND_DUE;
                        n_out_acc  = 1'b0;
                        n_out_id   = r_pend_id;
                        n_out_last = 1'b0;
                    end
                    n_pend_v  = 1'b1;
                    n_pend_id = r_idle_id;
                end
            end
            pits_pkg::ST_POLL_LAST: begin
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_kind = r_pend_v ? pits_pkg::KIND_DUE : pits_pkg::KIND_NONE;
                    n_out_acc  = 1'b0;
                    n_out_id   = r_pend_v ? r_pend_id : 8'd0;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pits_pkg::ST_IDLE;
            r_count   <= '0;
            r_ms      <= '0;
            r_idle_en <= 1'b0;
            r_idle_id <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ms     <= n_ms;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pits_pkg::CFG_IDLE_EN: r_idle_en <= i_cfg_wdata[0];
                    pits_pkg::CFG_IDLE_ID: r_idle_id <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pend_id  <= n_pend_id;
        r_task_id  <= n_task_id;
        r_prio     <= n_prio;
        r_interval <= n_interval;
        r_acc      <= n_acc;
        r_out_kind <= n_out_kind;
        r_out_acc  <= n_out_acc;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
    end

    assign o_out_valid   = r_out_v;
    assign o_result_kind = r_out_kind;
    assign o_accepted    = r_out_acc;
    assign o_due_id      = r_out_id;
    assign o_last_of_run = r_out_last;

endmodule

`default_nettype wire

[hdl/pits_checker.sv]
// Port-level checks for priority_interval_task_scheduler, attached by bind.
// Depends on pits_pkg (command and result codes).
`default_nettype none

module pits_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [1:0]  i_command,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_result_kind,
    input wire logic        o_accepted,
    input wire logic [7:0]  o_due_id,
    input wire logic        o_last_of_run
);

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_result_kind) && $stable(o_due_id)
            && $stable(o_accepted) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // Add status and nothing-due are always the single result of their item.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind != pits_pkg::KIND_DUE) |-> o_last_of_run)
        else $error("add status or nothing-due without run end");

    a_acc_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind != pits_pkg::KIND_ADD) |-> !o_accepted)
        else $error("accepted set on non-add result");

    a_id_only_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind != pits_pkg::KIND_DUE) |-> (o_due_id == 8'd0))
        else $error("due id set on non-due result");

    // A tick finishes in the cycle it is taken.
    a_tick_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == pits_pkg::CMD_TICK) |=> !o_in_stall)
        else $error("tick kept the block busy");

endmodule

bind priority_interval_task_scheduler pits_checker u_pits_checker (.*);

`default_nettype wire

[sim/sched_checker.sv]
`timescale 1ns / 1ps
// Checker for the task scheduler: keeps its own copy of the task table and
// predicts the results of each command. Depends on pits_pkg only.
module sched_checker #(
    parameter int SLOTS = pits_pkg::SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_task_id,
    input  wire logic [7:0]  i_priority_req,
    input  wire logic [15:0] i_interval,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_result_kind,
    input  wire logic        i_accepted,
    input  wire logic [7:0]  i_due_id,
    input  wire logic        i_last_of_run,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count
);

    typedef struct packed {
        logic [1:0] kind;
        logic       accepted;
        logic [7:0] due_id;
        logic       last;
    } t_sched_result;

    pits_pkg::t_slot task_tbl [SLOTS];
    int              task_cnt;
    logic [31:0]     ms_now;
    logic            idle_en;
    logic [7:0]      idle_id;
    t_sched_result   expected_q [$];

    // Sorted insert; equal priorities keep arrival order. New entry never ran.
    function automatic bit insert_task(logic [7:0] id, logic [7:0] prio, logic [15:0] ivl);
        int pos;
        if (task_cnt + int'(idle_en) >= SLOTS || task_cnt >= SLOTS) return 1'b0;
        if (prio >= pits_pkg::PRIO_LIMIT || ivl == 16'd0) return 1'b0;
        pos = task_cnt;
        for (int j = 0; j < task_cnt; j++) begin
            if (task_tbl[j].prio > prio) begin
                pos = j;
                break;
            end
        end
        for (int j = task_cnt; j > pos; j--) task_tbl[j] = task_tbl[j - 1];
        task_tbl[pos] = '{id: id, prio: prio, interval: ivl, run_stamp: 32'd0};
        task_cnt++;
        return 1'b1;
    endfunction

    function automatic void poll_tasks();
        logic [7:0] due_ids [$];
        for (int i = 0; i < task_cnt; i++) begin
            // elapsed time wraps modulo 2^32
            if (ms_now - task_tbl[i].run_stamp >= {16'd0, task_tbl[i].interval}) begin
                due_ids.push_back(task_tbl[i].id);
                task_tbl[i].run_stamp = ms_now;
            end
        end
        // idle task only when it actually owns a slot
        if (idle_en && task_cnt < SLOTS) due_ids.push_back(idle_id);
        if (due_ids.size() == 0) begin
            expected_q.push_back('{pits_pkg::KIND_NONE, 1'b0, 8'd0, 1'b1});
        end else begin
            foreach (due_ids[k])
                expected_q.push_back('{pits_pkg::KIND_DUE, 1'b0, due_ids[k],
                                       1'(k == due_ids.size() - 1)});
        end
    endfunction

    function automatic void predict_command();
        case (i_command)
            pits_pkg::CMD_ADD: begin
                expected_q.push_back('{pits_pkg::KIND_ADD,
                                       insert_task(i_task_id, i_priority_req, i_interval),
                                       8'd0, 1'b1});
            end
            pits_pkg::CMD_TICK: ms_now = ms_now + 32'd1;
            pits_pkg::CMD_POLL: poll_tasks();
            default: ;
        endcase
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%02h, got 0x%02h", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    function automatic void check_result();
        t_sched_result want;
        o_result_count++;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got kind %0d acc %0d id 0x%02h last %0d",
                     $time, i_result_kind, i_accepted, i_due_id, i_last_of_run);
            o_fail_count++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("result_kind", 8'(want.kind), 8'(i_result_kind));
        compare_field("accepted", 8'(want.accepted), 8'(i_accepted));
        compare_field("due_id", want.due_id, i_due_id);
        compare_field("last_of_run", 8'(want.last), 8'(i_last_of_run));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            task_cnt       = 0;
            ms_now         = '0;
            idle_en        = 1'b0;
            idle_id        = '0;
            o_fail_count   = 0;
            o_result_count = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == pits_pkg::CFG_IDLE_EN) idle_en = i_cfg_wdata[0];
                else idle_id = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) predict_command();
            if (i_out_valid && !i_out_stall) check_result();
        end
        o_pending = expected_q.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Top of the task scheduler testbench: clock, reset, command stimulus,
// output back-pressure, watchdog and verdict. Needs pits_pkg, sched_checker, the RTL.
module tb_top;

    localparam int         SLOTS       = pits_pkg::SLOTS_DEF;
    localparam logic [1:0] CMD_RSVD    = 2'd3;         // unused code, block ignores it
    localparam int         SETTLE      = 2 * SLOTS + 8; // covers a full-table add or poll
    localparam int         HOLD_CYCLES = 250;           // long output hold-off
    localparam int         QUIET_LIMIT = 4000;          // cycles with no item moving

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [7:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [7:0]  task_id;
    logic [7:0]  priority_req;
    logic [15:0] interval;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic        accepted;
    logic [7:0]  due_id;
    logic        last_of_run;

    int fail_count;
    int pending;
    int result_count;
    int quiet_cycles = 0;
    int sent_by_cmd [4] = '{0, 0, 0, 0};

    bit idling_on;   // random gaps on both sides
    bit hold_req;    // asks the receiver for one long hold-off

    always #5 clk = ~clk;

    priority_interval_task_scheduler u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_command      (command),
        .i_task_id      (task_id),
        .i_priority_req (priority_req),
        .i_interval     (interval),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_kind  (result_kind),
        .o_accepted     (accepted),
        .o_due_id       (due_id),
        .o_last_of_run  (last_of_run)
    );

    sched_checker #(.SLOTS(SLOTS)) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_command      (command),
        .i_task_id      (task_id),
        .i_priority_req (priority_req),
        .i_interval     (interval),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_result_kind  (result_kind),
        .i_accepted     (accepted),
        .i_due_id       (due_id),
        .i_last_of_run  (last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one item and hold it until the block takes it. Called and returns
    // at a falling edge. valid is raised once per call and lowered only for a
    // random gap, so a back-to-back item keeps valid high without a glitch.
    task automatic send_item(logic [1:0] cmd, logic [7:0] id, logic [7:0] prio,
                             logic [15:0] ivl);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        task_id      <= id;
        priority_req <= prio;
        interval     <= ivl;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        sent_by_cmd[cmd]++;
    endtask

    // Mix of commands. Add fields lean toward small priorities (ties, deep
    // inserts) and short intervals (tasks come due often), with the extremes
    // and the rejected values mixed in. Unused fields carry noise.
    task automatic run_random(int count, int add_pct);
        int          roll;
        logic [7:0]  prio;
        logic [15:0] ivl;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct) begin
                case ($urandom_range(0, 9))
                    0, 1:    prio = 8'($urandom_range(0, 255));
                    2:       prio = 8'(253 + $urandom_range(0, 2));
                    default: prio = 8'($urandom_range(0, 6));
                endcase
                case ($urandom_range(0, 9))
                    0:       ivl = 16'd0;
                    1:       ivl = 16'hFFFF;
                    2, 3:    ivl = 16'($urandom);
                    default: ivl = 16'($urandom_range(1, 6));
                endcase
                send_item(pits_pkg::CMD_ADD, 8'($urandom), prio, ivl);
            end else if (roll < add_pct + 40) begin
                send_item(pits_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
            end else if (roll < 96) begin
                send_item(pits_pkg::CMD_POLL, 8'($urandom), 8'($urandom), 16'($urandom));
            end else begin
                send_item(CMD_RSVD, 8'($urandom), 8'($urandom), 16'($urandom));
            end
        end
    endtask

    // Lower valid, wait until every predicted result is out, then give a
    // trailing tick or ignored command time to finish.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Registers change only with the block idle.
    task automatic set_idle(logic en, logic [7:0] id);
        drain_and_settle();
        write_reg(pits_pkg::CFG_IDLE_EN, {7'd0, en});
        write_reg(pits_pkg::CFG_IDLE_ID, id);
    endtask

    // Result side: random stall bursts, or one long counted hold-off on request.
    initial begin : receiver
        int held;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 6) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = pits_pkg::CFG_IDLE_EN;
        cfg_wdata    = 8'd0;
        in_valid     = 1'b0;
        command      = pits_pkg::CMD_TICK;
        task_id      = 8'd0;
        priority_req = 8'd0;
        interval     = 16'd0;
        out_stall    = 1'b0;
        idling_on    = 1'b1;
        hold_req     = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, idle task off.
        set_idle(1'b0, 8'h00);
        send_item(pits_pkg::CMD_POLL, 8'h5A, 8'h3C, 16'h1234);  // empty table: nothing due
        send_item(CMD_RSVD, 8'hFF, 8'hFF, 16'hFFFF);            // ignored, no result
        send_item(pits_pkg::CMD_TICK, 8'h00, 8'h00, 16'h0000);  // no result
        send_item(pits_pkg::CMD_ADD,  8'h01, 8'd254, 16'd5);    // priority at limit
        send_item(pits_pkg::CMD_ADD,  8'h02, 8'd255, 16'd5);    // top priority value
        send_item(pits_pkg::CMD_ADD,  8'h03, 8'd10,  16'd0);    // zero interval
        // highest legal priority, max interval
        send_item(pits_pkg::CMD_ADD,  8'hFF, 8'd253, 16'hFFFF);
        send_item(pits_pkg::CMD_ADD,  8'h00, 8'd0,   16'd1);    // goes to the front
        send_item(pits_pkg::CMD_ADD,  8'h11, 8'd5,   16'd2);
        send_item(pits_pkg::CMD_POLL, 8'hA5, 8'h5A, 16'hA5A5);
        send_item(pits_pkg::CMD_TICK, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(pits_pkg::CMD_TICK, 8'h00, 8'h00, 16'h0000);
        // stamps 0x11 with a nonzero time
        send_item(pits_pkg::CMD_POLL, 8'h00, 8'h00, 16'h0000);
        // lands in 0x11's slot; must start from time 0, so it is due at once
        send_item(pits_pkg::CMD_ADD,  8'h22, 8'd1,   16'd2);
        send_item(pits_pkg::CMD_ADD,  8'h33, 8'd5,   16'd4);    // tie, goes after 0x11
        send_item(pits_pkg::CMD_POLL, 8'hFF, 8'hFF, 16'hFFFF);

        // Idle task on: it runs on every poll.
        set_idle(1'b1, 8'hA5);
        send_item(pits_pkg::CMD_POLL, 8'h00, 8'hFF, 16'h00FF);
        send_item(pits_pkg::CMD_TICK, 8'h00, 8'h00, 16'h0000);
        send_item(pits_pkg::CMD_POLL, 8'hFF, 8'h00, 16'hFF00);

        // Idle task on with a random id; the table fills to capacity minus
        // the idle slot and further adds are refused.
        set_idle(1'b1, 8'($urandom));
        run_random(60, 20);
        // Long output hold-off while polls keep coming: the output register
        // fills and the block has to stall its input.
        hold_req = 1'b1;
        repeat (20) send_item(pits_pkg::CMD_POLL, 8'($urandom), 8'($urandom), 16'($urandom));
        run_random(60, 20);

        // Idle task off frees its slot, so the table can reach all entries.
        set_idle(1'b0, 8'hFF);
        run_random(110, 20);

        // Idle task enabled with a full table: it has no slot and stays silent.
        set_idle(1'b1, 8'h00);
        run_random(110, 15);

        // Last stretch with no gaps on either side.
        set_idle(1'b0, 8'($urandom));
        idling_on = 1'b0;
        run_random(100, 15);

        drain_and_settle();
        $display("Covered %0d adds, %0d ticks, %0d polls, %0d ignored items; %0d results checked.",
                 sent_by_cmd[pits_pkg::CMD_ADD], sent_by_cmd[pits_pkg::CMD_TICK],
                 sent_by_cmd[pits_pkg::CMD_POLL], sent_by_cmd[CMD_RSVD], result_count);
        $display("Idle task off and on (ids 0x00, 0xA5, 0xFF, random), full table, long hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[priority_interval_task_scheduler.f]
hdl/pits_pkg.sv
hdl/pits_slot_mem.sv
hdl/pits_cmp.sv
hdl/priority_interval_task_scheduler.sv
hdl/pits_checker.sv
sim/sched_checker.sv
sim/tb_top.sv
